[hw/rtl/trr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trr_pkg: shared types and constants of the TFTP read receiver
// Holds the classified event record, the action and error codes, and the
// block size that separates a full block from the final one.
// ----------------------------------------------------------------------------
package trr_pkg;

  // Payload bytes in a full DATA block; a packet of this plus the 4-byte
  // header, or longer, is a full block.
  localparam int BLOCK_PAYLOAD = 512;
  localparam logic [10:0] FULL_LENGTH = 11'(BLOCK_PAYLOAD + 4);

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] OP_DATA    = 8'h03;
  localparam logic [7:0] OP_ERR_MAX = 8'h05;

  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_RESEND_REQ = 3'd1;
  localparam logic [2:0] ACT_ACK        = 3'd2;
  localparam logic [2:0] ACT_ERROR      = 3'd3;
  localparam logic [2:0] ACT_DELIVER    = 3'd4;
  localparam logic [2:0] ACT_GIVE_UP    = 3'd5;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_ILLEGAL    = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN_ID = 3'd5;

  localparam logic [7:0] RETRY_MAX = 8'hff;

  // One event after classification by the front.
  typedef struct packed {
    logic        is_packet;
    logic [15:0] source_port;
    logic        is_data;
    logic        op_illegal;
    logic [15:0] block_number;
    logic        short_block;
  } trr_item_t;

endpackage : trr_pkg
`default_nettype wire

[hw/rtl/tftp_read_receiver.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tftp_read_receiver: receiving side of a TFTP read transfer
// Turns timeout ticks and parsed packet headers into protocol actions:
// resend request, acknowledge, error, deliver, or give up.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Carries
//  --------  ----------------------  ------------------------------------------
//  input     in_valid / in_stall     command, source_port, packet_opcode,
//                                    block_number, byte_count
//  output    out_valid / out_stall   action, ack_block, err_code, finished
//  config    cfg_valid / cfg_ready   max_retries
//
//  An event is accepted every cycle while the event queue has room. The
//  event is first written into the queue and is then loaded into the back's
//  output register, where the result becomes valid. The back takes one
//  event per cycle while the output is not stalled, updating the transfer
//  state as it loads each result.
//  Reset is synchronous: the transfer state returns to its start, the queue
//  empties and max_retries goes back to 5. A stall on the output holds the
//  result register and the back; the queue then fills and raises in_stall.
//
// The front classifies each event (DATA opcode, illegal opcode, short block)
// without looking at any state. The queue decouples it from the back, which
// owns the transfer ID, block counters, retry count and phase, and produces
// exactly one result per event. Configuration writes are always ready; the
// user must issue them only while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
module tftp_read_receiver #(
  parameter int QUEUE_DEPTH = trr_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  max_retries,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [15:0] source_port,
  input  wire logic [7:0]  packet_opcode,
  input  wire logic [15:0] block_number,
  input  wire logic [9:0]  byte_count,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       action,
  output logic [15:0]      ack_block,
  output logic [2:0]       err_code,
  output logic             finished
);
  import trr_pkg::*;

  localparam logic [7:0] MAX_RETRIES_RESET = 8'd5;

  // Retry limit register, written by the configuration transfer.
  logic [7:0] retry_limit;

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_not_empty;
  trr_item_t q_item;
  trr_item_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= MAX_RETRIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      retry_limit <= max_retries;
    end
  end

  // Front: intake and classification of each event.
  trr_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .source_port   (source_port),
    .packet_opcode (packet_opcode),
    .block_number  (block_number),
    .byte_count    (byte_count),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_item)
  );

  // Queue between front and back.
  trr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back: transfer state machine and output register.
  trr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .max_retries (retry_limit),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .action      (action),
    .ack_block   (ack_block),
    .err_code    (err_code),
    .finished    (finished)
  );

endmodule : tftp_read_receiver
`default_nettype wire

[hw/rtl/trr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trr_front: event intake and classification
// Accepts events while the queue has room and reduces the opcode and length
// to the flags the back needs.
// ----------------------------------------------------------------------------
module trr_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              command,
  input  wire logic [15:0]       source_port,
  input  wire logic [7:0]        packet_opcode,
  input  wire logic [15:0]       block_number,
  input  wire logic [9:0]        byte_count,
  input  wire logic              q_full,
  output logic                   q_push,
  output trr_pkg::trr_item_t     q_item
);
  import trr_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.is_packet    = command;
    q_item.source_port  = source_port;
    q_item.is_data      = (packet_opcode == OP_DATA);
    q_item.op_illegal   = (packet_opcode > OP_ERR_MAX);
    q_item.block_number = block_number;
    q_item.short_block  = ({1'b0, byte_count} < FULL_LENGTH);
  end

endmodule : trr_front
`default_nettype wire

[hw/rtl/trr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trr_queue: short event queue between front and back
// A small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module trr_queue #(
  parameter int DEPTH = trr_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire trr_pkg::trr_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    not_empty,
  output trr_pkg::trr_item_t      head
);
  import trr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  trr_item_t       entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : trr_queue
`default_nettype wire

[hw/rtl/trr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trr_back: transfer state and result generation
// Takes one classified event per cycle from the queue unless the output
// stalls, updates transfer state, loads the result into the output register.
// ----------------------------------------------------------------------------
module trr_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         max_retries,
  input  wire logic               q_not_empty,
  input  wire trr_pkg::trr_item_t q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              action,
  output logic [15:0]             ack_block,
  output logic [2:0]              err_code,
  output logic                    finished
);
  import trr_pkg::*;

  localparam logic [1:0] PHASE_RUN    = 2'd0;
  localparam logic [1:0] PHASE_DONE   = 2'd1;
  localparam logic [1:0] PHASE_FAILED = 2'd2;

  logic [15:0] transfer_id;
  logic        id_latched;
  logic [15:0] last_seen_block;
  logic [15:0] expected_block;
  logic [7:0]  retry_count;
  logic [1:0]  phase;

  logic [15:0] transfer_id_next;
  logic        id_latched_next;
  logic [15:0] last_seen_block_next;
  logic [15:0] expected_block_next;
  logic [7:0]  retry_count_next;
  logic [1:0]  phase_next;
  logic [2:0]  action_next;
  logic [15:0] ack_block_next;
  logic [2:0]  err_code_next;

  logic [7:0]  retry_inc;
  logic        limit_hit;
  logic [15:0] last_done;
  logic [15:0] id_seen;

  assign q_pop = q_not_empty && (!out_valid || !out_stall);

  always_comb begin
    retry_inc = (retry_count == RETRY_MAX) ? RETRY_MAX : retry_count + 8'd1;
    limit_hit = (retry_inc >= max_retries);
    last_done = expected_block - 16'd1;
    id_seen   = id_latched ? transfer_id : q_head.source_port;

    transfer_id_next     = transfer_id;
    id_latched_next      = id_latched;
    last_seen_block_next = last_seen_block;
    expected_block_next  = expected_block;
    retry_count_next     = retry_count;
    phase_next           = phase;
    action_next          = ACT_NONE;
    ack_block_next       = 16'd0;
    err_code_next        = ERR_NONE;

    if (phase == PHASE_RUN) begin
      if (!q_head.is_packet) begin
        // Receive timeout.
        retry_count_next = retry_inc;
        if (limit_hit) begin
          phase_next  = PHASE_FAILED;
          action_next = ACT_GIVE_UP;
        end else if (last_seen_block == 16'd0) begin
          action_next = ACT_RESEND_REQ;
        end else begin
          action_next    = ACT_ACK;
          ack_block_next = last_done;
        end
      end else begin
        transfer_id_next = id_seen;
        id_latched_next  = 1'b1;
        if (q_head.source_port != id_seen) begin
          action_next   = ACT_ERROR;
          err_code_next = ERR_UNKNOWN_ID;
        end else begin
          last_seen_block_next = q_head.block_number;
          if (!q_head.is_data) begin
            retry_count_next = retry_inc;
            if (limit_hit) begin
              phase_next  = PHASE_FAILED;
              action_next = ACT_GIVE_UP;
            end else if (q_head.op_illegal) begin
              action_next   = ACT_ERROR;
              err_code_next = ERR_ILLEGAL;
            end
          end else if (q_head.block_number != expected_block) begin
            action_next    = ACT_ACK;
            ack_block_next = last_done;
          end else begin
            action_next         = ACT_DELIVER;
            ack_block_next      = expected_block;
            expected_block_next = expected_block + 16'd1;
            retry_count_next    = 8'd0;
            if (q_head.short_block) begin
              phase_next = PHASE_DONE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_id     <= '0;
      id_latched      <= 1'b0;
      last_seen_block <= '0;
      expected_block  <= 16'd1;
      retry_count     <= '0;
      phase           <= PHASE_RUN;
      out_valid       <= 1'b0;
    end else begin
      if (q_pop) begin
        transfer_id     <= transfer_id_next;
        id_latched      <= id_latched_next;
        last_seen_block <= last_seen_block_next;
        expected_block  <= expected_block_next;
        retry_count     <= retry_count_next;
        phase           <= phase_next;
        out_valid       <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      action    <= action_next;
      ack_block <= ack_block_next;
      err_code  <= err_code_next;
      finished  <= (phase_next == PHASE_DONE);
    end
  end

endmodule : trr_back
`default_nettype wire

[tb/tftp_read_receiver_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftp_read_receiver_tb: self-checking bench for the TFTP read receiver
// Drives timeout ticks and packet headers into the block and predicts each
// protocol action from a local copy of the transfer state. A short table of
// hand-picked events comes first, then a short run of in-order blocks.
// Random phases follow under several retry limits, and the run closes with
// a completion or a give-up.
// ----------------------------------------------------------------------------
module tftp_read_receiver_tb;
  import trr_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int PRESSURE_ITEMS  = 24;
  localparam int RUNUP_ITEMS     = 40;
  localparam int PHASE_ITEMS     = 220;
  localparam int NUM_PHASES      = 6;
  localparam int TRAILING_ITEMS  = 12;
  localparam int MAX_REPORTS     = 40;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  localparam logic CMD_TIMEOUT = 1'b0;
  localparam logic CMD_PACKET  = 1'b1;

  localparam logic [7:0]  OP_ACK   = 8'h04;
  localparam logic [9:0]  LEN_FULL = 10'(BLOCK_PAYLOAD + 4);
  localparam logic [9:0]  LEN_MAX  = 10'h3ff;
  // Port of the first packet in the directed table; it becomes the transfer ID.
  localparam logic [15:0] TID      = 16'hffff;

  typedef enum logic [1:0] {
    XFER_RUN,
    XFER_DONE,
    XFER_FAILED
  } xfer_phase_e;

  typedef struct packed {
    logic        cmd;
    logic [15:0] port;
    logic [7:0]  opcode;
    logic [15:0] blk;
    logic [9:0]  len;
  } rx_event_t;

  typedef struct packed {
    logic [2:0]  act;
    logic [15:0] ack;
    logic [2:0]  err;
    logic        fin;
  } reply_t;

  typedef struct packed {
    logic [15:0] tid;
    logic        tid_valid;
    logic [15:0] last_block_seen;
    logic [15:0] next_block;
    logic [7:0]  retries;
    xfer_phase_e phase;
  } xfer_state_t;

  typedef struct packed {
    xfer_state_t st;
    reply_t      rep;
  } transfer_step_t;

  typedef struct packed {
    rx_event_t ev;
    logic      typed;
    reply_t    rep;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  max_retries = 8'd0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = 1'b0;
  logic [15:0] source_port = 16'd0;
  logic [7:0]  packet_opcode = 8'd0;
  logic [15:0] block_number = 16'd0;
  logic [9:0]  byte_count = 10'd0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  action;
  logic [15:0] ack_block;
  logic [2:0]  err_code;
  logic        finished;

  tftp_read_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .max_retries  (max_retries),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .source_port  (source_port),
    .packet_opcode(packet_opcode),
    .block_number (block_number),
    .byte_count   (byte_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .action       (action),
    .ack_block    (ack_block),
    .err_code     (err_code),
    .finished     (finished)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Predicted transfer state and the retry limit the block currently holds.
  xfer_state_t xfer;
  logic [7:0]  retry_limit;
  reply_t      expected_replies[$];
  int unsigned fail_count = 0;

  // Traffic shaping shared by the sender and the receiver.
  bit quiet = 1'b0;         // neither side idles
  bit back_to_back = 1'b0;  // the sender never idles
  bit hold_off_req = 1'b0;  // ask the receiver for one long stall
  bit holding = 1'b0;       // the receiver is inside that long stall

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // A timeout or a non-DATA packet from the transfer port counts toward the
  // limit; the counter saturates and the transfer fails once it reaches it.
  function automatic xfer_state_t count_retry(xfer_state_t s, logic [7:0] limit);
    if (s.retries != RETRY_MAX) s.retries = s.retries + 8'd1;
    if (s.retries >= limit) s.phase = XFER_FAILED;
    return s;
  endfunction

  function automatic transfer_step_t advance_transfer(xfer_state_t s, logic [7:0] limit,
                                                      rx_event_t ev);
    transfer_step_t t;
    logic [15:0] last_done;
    t.rep = '0;
    last_done = s.next_block - 16'd1;
    if (s.phase == XFER_RUN) begin
      if (ev.cmd == CMD_TIMEOUT) begin
        s = count_retry(s, limit);
        if (s.phase == XFER_FAILED) begin
          t.rep.act = ACT_GIVE_UP;
        end else if (s.last_block_seen == 16'd0) begin
          t.rep.act = ACT_RESEND_REQ;
        end else begin
          t.rep.act = ACT_ACK;
          t.rep.ack = last_done;
        end
      end else begin
        if (!s.tid_valid) begin
          s.tid = ev.port;
          s.tid_valid = 1'b1;
        end
        if (ev.port != s.tid) begin
          t.rep.act = ACT_ERROR;
          t.rep.err = ERR_UNKNOWN_ID;
        end else begin
          s.last_block_seen = ev.blk;
          if (ev.opcode != OP_DATA) begin
            s = count_retry(s, limit);
            if (s.phase == XFER_FAILED) begin
              t.rep.act = ACT_GIVE_UP;
            end else if (ev.opcode > OP_ERR_MAX) begin
              t.rep.act = ACT_ERROR;
              t.rep.err = ERR_ILLEGAL;
            end
          end else if (ev.blk != s.next_block) begin
            t.rep.act = ACT_ACK;
            t.rep.ack = last_done;
          end else begin
            t.rep.act = ACT_DELIVER;
            t.rep.ack = s.next_block;
            s.next_block = s.next_block + 16'd1;
            s.retries = 8'd0;
            if ({1'b0, ev.len} < FULL_LENGTH) s.phase = XFER_DONE;
          end
        end
      end
    end
    t.rep.fin = (s.phase == XFER_DONE);
    t.st = s;
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Event generation
  // --------------------------------------------------------------------------

  function automatic row_t table_row(logic cmd, logic [15:0] port, logic [7:0] opcode,
                                     logic [15:0] blk, logic [9:0] len, logic typed,
                                     logic [2:0] act, logic [15:0] ack, logic [2:0] err);
    row_t r;
    r.ev = '{cmd: cmd, port: port, opcode: opcode, blk: blk, len: len};
    r.typed = typed;
    r.rep = '{act: act, ack: ack, err: err, fin: 1'b0};
    return r;
  endfunction

  function automatic rx_event_t noise_event();
    rx_event_t ev;
    ev.cmd = 1'($urandom_range(0, 1));
    ev.port = $urandom_range(0, 1) ? xfer.tid : 16'($urandom);
    ev.opcode = 8'($urandom);
    ev.blk = 16'($urandom);
    ev.len = 10'($urandom);
    return ev;
  endfunction

  // The next block in order, always full length.
  function automatic rx_event_t delivery_event();
    rx_event_t ev;
    ev.cmd = CMD_PACKET;
    ev.port = xfer.tid;
    ev.opcode = OP_DATA;
    ev.blk = xfer.next_block;
    ev.len = ($urandom_range(0, 9) == 0) ? LEN_FULL : 10'($urandom_range(LEN_FULL, LEN_MAX));
    return ev;
  endfunction

  // Either a timeout or a non-DATA packet from the transfer port.
  function automatic rx_event_t counted_event();
    rx_event_t ev;
    ev = noise_event();
    if ($urandom_range(0, 1)) begin
      ev.cmd = CMD_TIMEOUT;
    end else begin
      ev.cmd = CMD_PACKET;
      ev.port = xfer.tid;
      if ($urandom_range(0, 9) < 3) begin
        ev.opcode = 8'($urandom_range(0, 4));
        if (ev.opcode >= OP_DATA) ev.opcode = ev.opcode + 8'd1;
      end else begin
        ev.opcode = 8'($urandom_range(OP_ERR_MAX + 1, 255));
      end
      if ($urandom_range(0, 3) == 0) ev.blk = 16'd0;
    end
    return ev;
  endfunction

  // Mostly a well-formed transfer with duplicates, timeouts and stray packets
  // mixed in. Anything that would end the transfer is drawn again, so the
  // random phases keep the block busy until the closing sequence.
  function automatic rx_event_t random_event();
    rx_event_t ev;
    transfer_step_t peek;
    int unsigned r;
    do begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        ev = delivery_event();
      end else if (r < 57) begin
        ev = delivery_event();
        case ($urandom_range(0, 3))
          0, 1: ev.blk = xfer.next_block - 16'd1;
          2: ev.blk = xfer.next_block + 16'd1;
          default: ev.blk = 16'($urandom);
        endcase
        ev.len = 10'($urandom);
      end else if (r < 79) begin
        ev = counted_event();
      end else if (r < 89) begin
        ev = noise_event();
        ev.cmd = CMD_PACKET;
        if (ev.port == xfer.tid) ev.port = ~xfer.tid;
      end else begin
        ev = noise_event();
      end
      peek = advance_transfer(xfer, retry_limit, ev);
    end while (peek.st.phase != XFER_RUN);
    return ev;
  endfunction

  // Idle cycles before the next transfer: mostly none, some short, a few long.
  function automatic int pick_gap();
    int unsigned r;
    if (quiet || back_to_back) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Called at a rising edge. The stall is sampled at the falling edge, where
  // everything has settled, and the transfer takes place at the next rising
  // edge. The prediction is made once the event has been accepted.
  task automatic send_event(input rx_event_t ev, input logic typed, input reply_t typed_rep);
    int gap;
    logic taken;
    transfer_step_t nxt;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= ev.cmd;
    source_port   <= ev.port;
    packet_opcode <= ev.opcode;
    block_number  <= ev.blk;
    byte_count    <= ev.len;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    nxt = advance_transfer(xfer, retry_limit, ev);
    xfer = nxt.st;
    expected_replies.push_back(typed ? typed_rep : nxt.rep);
  endtask

  // Stops offering events and waits until every predicted result is out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_retry_limit(input logic [7:0] value);
    logic taken;
    cfg_valid   <= 1'b1;
    max_retries <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    retry_limit = value;
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  task automatic note_mismatch(input string field, input int want, input int got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // Outputs are read at the falling edge; a result is taken when valid is up
  // and the stall is down, and the transfer completes at the next rising edge.
  initial begin
    reply_t want;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("result with nothing expected: action %0d ack_block %0d", action, ack_block);
        end else begin
          want = expected_replies.pop_front();
          if (action !== want.act) note_mismatch("action", want.act, action);
          if (ack_block !== want.ack) note_mismatch("ack_block", want.ack, ack_block);
          if (err_code !== want.err) note_mismatch("err_code", want.err, err_code);
          if (finished !== want.fin) note_mismatch("finished", want.fin, finished);
        end
      end
    end
  end

  // Receiver stall pattern. Each step holds one level for a random number of
  // cycles; a requested hold-off is one long stall that lets the block fill.
  initial begin
    int dur;
    logic level;
    int unsigned r;
    @(posedge clk);
    forever begin
      holding = 1'b0;
      if (hold_off_req) begin
        level = 1'b1;
        dur = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
        holding = 1'b1;
      end else if (quiet) begin
        level = 1'b0;
        dur = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          level = 1'b0;
          dur = $urandom_range(1, 12);
        end else if (r < 85) begin
          level = 1'b1;
          dur = $urandom_range(1, 2);
        end else if (r < 96) begin
          level = 1'b1;
          dur = $urandom_range(3, 8);
        end else begin
          level = 1'b1;
          dur = $urandom_range(15, 40);
        end
      end
      out_stall <= level;
      repeat (dur) @(posedge clk);
    end
  end

  // Watchdog.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    row_t plan[16];
    logic [7:0] phase_limits[NUM_PHASES];
    rx_event_t ev;

    // Directed events under the reset retry limit of 5. Expected results are
    // written out where they are obvious; the rest come from the predictor.
    plan[0]  = table_row(CMD_TIMEOUT, 16'h0000, 8'h00, 16'h0000, 10'd0, 1'b1,
                         ACT_RESEND_REQ, 16'd0, ERR_NONE);
    plan[1]  = table_row(CMD_PACKET, TID, OP_DATA, 16'd1, LEN_FULL, 1'b1,
                         ACT_DELIVER, 16'd1, ERR_NONE);
    plan[2]  = table_row(CMD_PACKET, 16'h0000, OP_DATA, 16'd2, LEN_MAX, 1'b1,
                         ACT_ERROR, 16'd0, ERR_UNKNOWN_ID);
    plan[3]  = table_row(CMD_TIMEOUT, 16'h5a5a, OP_DATA, 16'd1, 10'h2aa, 1'b0,
                         ACT_NONE, 16'd0, ERR_NONE);
    plan[4]  = table_row(CMD_PACKET, TID, OP_DATA, 16'd7, LEN_FULL, 1'b0,
                         ACT_NONE, 16'd0, ERR_NONE);
    plan[5]  = table_row(CMD_PACKET, TID, 8'hff, 16'hffff, 10'd0, 1'b1,
                         ACT_ERROR, 16'd0, ERR_ILLEGAL);
    plan[6]  = table_row(CMD_PACKET, TID, 8'h00, 16'h0000, 10'd3, 1'b0,
                         ACT_NONE, 16'd0, ERR_NONE);
    plan[7]  = table_row(CMD_PACKET, TID, OP_DATA, 16'd2, LEN_MAX, 1'b0,
                         ACT_NONE, 16'd0, ERR_NONE);
    plan[8]  = table_row(CMD_TIMEOUT, 16'hffff, 8'hff, 16'hffff, LEN_MAX, 1'b0,
                         ACT_NONE, 16'd0, ERR_NONE);
    plan[9]  = table_row(CMD_PACKET, TID, OP_ERR_MAX, 16'h0000, LEN_MAX, 1'b0,
                         ACT_NONE, 16'd0, ERR_NONE);
    plan[10] = table_row(CMD_TIMEOUT, 16'h0001, 8'h01, 16'h0001, 10'd1, 1'b0,
                         ACT_NONE, 16'd0, ERR_NONE);
    plan[11] = table_row(CMD_PACKET, TID, OP_ERR_MAX + 8'd1, 16'd3, 10'd600, 1'b1,
                         ACT_ERROR, 16'd0, ERR_ILLEGAL);
    plan[12] = table_row(CMD_PACKET, 16'hfffe, OP_DATA, 16'd3, LEN_FULL, 1'b1,
                         ACT_ERROR, 16'd0, ERR_UNKNOWN_ID);
    plan[13] = table_row(CMD_PACKET, TID, OP_DATA, 16'd3, LEN_FULL, 1'b0,
                         ACT_NONE, 16'd0, ERR_NONE);
    plan[14] = table_row(CMD_PACKET, TID, OP_DATA, 16'd3, 10'd0, 1'b0,
                         ACT_NONE, 16'd0, ERR_NONE);
    plan[15] = table_row(CMD_PACKET, TID, OP_ACK, 16'hffff, LEN_MAX, 1'b0,
                         ACT_NONE, 16'd0, ERR_NONE);

    // Retry limits for the random phases, both extremes among them.
    phase_limits[0] = 8'd255;
    phase_limits[1] = 8'd1;
    phase_limits[2] = 8'($urandom_range(2, 254));
    phase_limits[3] = 8'd5;
    phase_limits[4] = 8'd1;
    phase_limits[5] = 8'($urandom_range(2, 254));

    xfer.tid = 16'd0;
    xfer.tid_valid = 1'b0;
    xfer.last_block_seen = 16'd0;
    xfer.next_block = 16'd1;
    xfer.retries = 8'd0;
    xfer.phase = XFER_RUN;
    retry_limit = 8'd5;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < 16; k++) send_event(plan[k].ev, plan[k].typed, plan[k].rep);

    // A short run of in-order blocks with neither side idling.
    wait_idle();
    write_retry_limit(8'd255);
    quiet = 1'b1;
    repeat (RUNUP_ITEMS) send_event(delivery_event(), 1'b0, '0);
    quiet = 1'b0;

    // Random phases. Each starts from an idle block with a new retry limit.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_retry_limit(phase_limits[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (p == 2 && i == 100) begin
          // Long receiver hold-off while the sender keeps offering events,
          // so the queue fills and the input stalls.
          in_valid <= 1'b0;
          hold_off_req = 1'b1;
          @(posedge clk);
          while (!holding) @(posedge clk);
          back_to_back = 1'b1;
          repeat (PRESSURE_ITEMS) send_event(random_event(), 1'b0, '0);
          back_to_back = 1'b0;
        end
        send_event(random_event(), 1'b0, '0);
      end
    end
    quiet = 1'b0;

    // Close the transfer: either a final short block or counted events until
    // the block gives up, sometimes under the largest retry limit.
    wait_idle();
    if ($urandom_range(0, 1)) begin
      ev = delivery_event();
      ev.len = $urandom_range(0, 1) ? LEN_FULL - 10'd1 : 10'($urandom_range(0, LEN_FULL - 1));
      send_event(ev, 1'b0, '0);
    end else begin
      if ($urandom_range(0, 1)) write_retry_limit(8'd255);
      while (xfer.phase == XFER_RUN) send_event(counted_event(), 1'b0, '0);
    end

    // Everything after the end of the transfer must be ignored.
    repeat (TRAILING_ITEMS) send_event(noise_event(), 1'b0, '0);

    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
